>>> rtl/sle_pkg.sv
// types and constants shared by the list engine control and its cells
// no dependencies
`default_nettype none

package sle_pkg;

  localparam int TGT_W = 13;

  typedef enum logic [1:0] {
    ACT_FIND   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_UPDATE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_DELETE,
    CMD_UPDATE,
    CMD_LOAD,
    CMD_SHIFT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [TGT_W-1:0]   tgt;
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

`default_nettype wire

>>> rtl/sequential_list_engine_unit.sv
// top level of the list engine: control plus a chain of entry cells
// depends on sle_pkg, sle_ctrl, sle_cell
//
//  channel  | dir | fields (lsb first)                                    | beat when
//  s_axis   | in  | action[1:0] position[8:2] write_value[40:9]           | tvalid & tready
//  m_axis   | out | status[0] read_value[32:1] entry_count[39:33] is_empty[40] | tvalid & tready
//  cfg      | in  | capacity[6:0]                                         | cfg_wr_en
//
// insert, delete, update and rejected requests: the result is registered as the cells update;
// insert and delete shift the upper part of the list in parallel
// find: the addressed cell loads the read tap, which ripples cell to cell to the chain end
// the result register frees the input side once a result is taken or being taken
// reset clears count, capacity to 64 and the handshake; entries stay unwritten
`default_nettype none

module sequential_list_engine_unit #(
  parameter int DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data,   // capacity
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,       // action, position, write_value, zero pad
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata        // status, read_value, entry_count, is_empty, pad
);

  sle_pkg::cell_cmd_t cmd;
  logic [31:0] val_w  [DEPTH];
  logic [31:0] hold_w [DEPTH];

  sle_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .action     (s_tdata[1:0]),
    .position   (s_tdata[8:2]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata),
    .scan_data  (hold_w[DEPTH-1]),
    .cmd        (cmd)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] prev_v;
    logic [31:0] next_v;
    logic [31:0] prev_h;

    if (i == 0) begin : g_first
      assign prev_v = 32'd0;
      assign prev_h = 32'd0;
    end else begin : g_mid
      assign prev_v = val_w[i-1];
      assign prev_h = hold_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_v = val_w[i];
    end else begin : g_inner
      assign next_v = val_w[i+1];
    end

    sle_cell #(
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .wval     (s_tdata[40:9]),
      .prev_val (prev_v),
      .next_val (next_v),
      .prev_hold(prev_h),
      .val      (val_w[i]),
      .hold     (hold_w[i])
    );
  end

endmodule

`default_nettype wire

>>> rtl/sle_cell.sv
// one list slot: holds an entry and a read tap, passes both to its neighbors
// depends on sle_pkg
`default_nettype none

module sle_cell #(
  parameter int IDX = 0
) (
  input  wire logic              clk,
  input  wire sle_pkg::cell_cmd_t cmd,
  input  wire logic [31:0]       wval,
  input  wire logic [31:0]       prev_val,
  input  wire logic [31:0]       next_val,
  input  wire logic [31:0]       prev_hold,
  output logic [31:0]            val,
  output logic [31:0]            hold
);

  localparam logic [sle_pkg::TGT_W-1:0] IDX_V = sle_pkg::TGT_W'(IDX);

  logic [31:0] val_next;
  logic [31:0] hold_next;
  logic        hit;
  logic        above;

  assign hit   = (cmd.tgt == IDX_V);
  assign above = (IDX_V > cmd.tgt);

  always_comb begin
    val_next  = val;
    hold_next = hold;
    case (cmd.kind)
      sle_pkg::CMD_INSERT: begin
        if (above) begin
          val_next = prev_val;
        end else if (hit) begin
          val_next = wval;
        end
      end
      sle_pkg::CMD_DELETE: begin
        if (above || hit) begin
          val_next = next_val;
        end
      end
      sle_pkg::CMD_UPDATE: begin
        if (hit) begin
          val_next = wval;
        end
      end
      sle_pkg::CMD_LOAD: begin
        hold_next = hit ? val : 32'd0;
      end
      sle_pkg::CMD_SHIFT: begin
        hold_next = prev_hold;
      end
      default: begin
        val_next  = val;
        hold_next = hold;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val  <= val_next;
    hold <= hold_next;
  end

endmodule

`default_nettype wire

>>> rtl/sle_ctrl.sv
// request checking, count and capacity, read scan sequencing, result register
// depends on sle_pkg
`default_nettype none

module sle_ctrl #(
  parameter int DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [6:0]         cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         action,
  input  wire logic [6:0]         position,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [47:0]             out_data,
  input  wire logic [31:0]        scan_data,
  output sle_pkg::cell_cmd_t      cmd
);

  localparam int CW     = $clog2(DEPTH + 1);
  localparam int KW     = ((CW > 7) ? CW : 7) + 1;
  localparam int CNT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sle_pkg::state_t  state;
  sle_pkg::state_t  state_next;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [6:0]       capacity;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             out_valid_next;
  logic [47:0]      out_data_next;

  logic             accept;
  logic             out_free;
  logic             pos_neg;
  logic [5:0]       pos_lo;
  logic             in_list;
  logic             limit_hit;
  logic             ins_ok;
  logic             req_ok;
  logic             scan_done;
  logic [KW-1:0]    limit;
  sle_pkg::action_t act;

  assign act      = sle_pkg::action_t'(action);
  assign out_free = !out_valid || out_ready;
  assign in_ready = !rst && (state == sle_pkg::ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign pos_neg  = position[6];
  assign pos_lo   = position[5:0];
  assign in_list  = !pos_neg && (KW'(pos_lo) < KW'(count));
  assign limit    = (KW'(capacity) < KW'(DEPTH)) ? KW'(capacity) : KW'(DEPTH);
  assign limit_hit = (KW'(count) >= limit);
  assign ins_ok   = (in_list || (position == 7'h7f)) && !limit_hit;
  assign req_ok   = (act == sle_pkg::ACT_INSERT) ? ins_ok : in_list;
  assign scan_done = (state == sle_pkg::ST_SCAN) && (cnt == '0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sle_pkg::ST_IDLE: begin
        if (accept && (act == sle_pkg::ACT_FIND) && req_ok) begin
          state_next = sle_pkg::ST_SCAN;
        end
      end
      sle_pkg::ST_SCAN: begin
        if (scan_done && out_free) begin
          state_next = sle_pkg::ST_IDLE;
        end
      end
      default: state_next = sle_pkg::ST_IDLE;
    endcase
  end

  // cell commands, count, scan counter, result
  always_comb begin
    cmd.kind       = sle_pkg::CMD_NONE;
    cmd.tgt        = sle_pkg::TGT_W'(pos_lo);
    count_next     = count;
    cnt_next       = cnt;
    out_valid_next = out_ready ? 1'b0 : out_valid;
    out_data_next  = out_data;
    case (state)
      sle_pkg::ST_IDLE: begin
        if (accept) begin
          if (req_ok) begin
            case (act)
              sle_pkg::ACT_FIND: begin
                cmd.kind = sle_pkg::CMD_LOAD;
                cnt_next = CNT_W'(DEPTH - 1) - CNT_W'(pos_lo);
              end
              sle_pkg::ACT_INSERT: begin
                cmd.kind   = sle_pkg::CMD_INSERT;
                cmd.tgt    = pos_neg ? '0 : sle_pkg::TGT_W'(pos_lo) + 1'b1;
                count_next = count + 1'b1;
              end
              sle_pkg::ACT_DELETE: begin
                cmd.kind   = sle_pkg::CMD_DELETE;
                count_next = count - 1'b1;
              end
              default: begin
                cmd.kind = sle_pkg::CMD_UPDATE;
              end
            endcase
          end
          if (!(req_ok && (act == sle_pkg::ACT_FIND))) begin
            out_valid_next = 1'b1;
            out_data_next  = {7'd0, (count_next == '0), 7'(count_next), 32'd0, !req_ok};
          end
        end
      end
      sle_pkg::ST_SCAN: begin
        if (!scan_done) begin
          cmd.kind = sle_pkg::CMD_SHIFT;
          cnt_next = cnt - 1'b1;
        end else if (out_free) begin
          out_valid_next = 1'b1;
          out_data_next  = {7'd0, (count == '0), 7'(count), scan_data, 1'b0};
        end
      end
      default: begin
        cmd.kind = sle_pkg::CMD_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sle_pkg::ST_IDLE;
      count     <= '0;
      capacity  <= 7'd64;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      cnt       <= cnt_next;
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
    end
    out_data <= out_data_next;
  end

  a_scan_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == sle_pkg::ST_SCAN) |-> !in_ready)
    else $error("input taken during read scan");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (accept && (act == sle_pkg::ACT_INSERT) && req_ok) |=> (count == $past(count) + 1'b1))
    else $error("insert did not grow the list");

  a_delete_count: assert property (@(posedge clk) disable iff (rst)
    (accept && (act == sle_pkg::ACT_DELETE) && req_ok) |=> (count == $past(count) - 1'b1))
    else $error("delete did not shrink the list");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data[0]) |-> (out_data[32:1] == 32'd0))
    else $error("error result carries a read value");

endmodule

`default_nettype wire

>>> tb/sequential_list_engine_unit_tb.sv
// testbench for sequential_list_engine_unit: directed and random list requests under stalls
// a scoreboard class keeps its own copy of the list and checks every result beat
// depends on sle_pkg and the rtl top level
`default_nettype none

module sequential_list_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int LIMIT = 600000;
  localparam int LONG_HOLD = 300;

  typedef struct {
    logic        status;
    logic [31:0] read_value;
    logic [6:0]  entry_count;
    logic        is_empty;
  } list_result_t;

  class list_scoreboard;
    logic [31:0]  entries [DEPTH];
    int           count;
    int           capacity;
    int           errors;
    list_result_t expected_q [$];

    function new();
      foreach (entries[i]) entries[i] = '0;
      count = 0;
      capacity = 64;
      errors = 0;
    endfunction

    function void set_capacity(logic [6:0] value);
      capacity = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(sle_pkg::action_t act, logic signed [6:0] pos,
                               logic [31:0] wval);
      int p;
      int lim;
      bit in_list;
      bit err;
      list_result_t r;
      p = pos;
      lim = (capacity < DEPTH) ? capacity : DEPTH;
      in_list = (p >= 0) && (p < count);
      err = 1'b0;
      r.read_value = '0;
      case (act)
        sle_pkg::ACT_FIND: begin
          if (in_list) r.read_value = entries[p];
          else err = 1'b1;
        end
        sle_pkg::ACT_INSERT: begin
          if (p < -1 || p >= count || count >= lim) begin
            err = 1'b1;
          end else begin
            for (int j = count; j > p + 1; j--) entries[j] = entries[j-1];
            entries[p+1] = wval;
            count++;
          end
        end
        sle_pkg::ACT_DELETE: begin
          if (in_list) begin
            for (int j = p + 1; j < count; j++) entries[j-1] = entries[j];
            count--;
          end else begin
            err = 1'b1;
          end
        end
        default: begin
          if (in_list) entries[p] = wval;
          else err = 1'b1;
        end
      endcase
      r.status = err;
      r.entry_count = count[6:0];
      r.is_empty = (count == 0);
      expected_q.push_back(r);
    endfunction

    function void report(string field, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, got_v);
      end
    endfunction

    function void check_result(logic [47:0] d);
      list_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, expected none, actual %h",
                 $time, d);
        return;
      end
      e = expected_q.pop_front();
      report("status", 32'(e.status), 32'(d[0]));
      report("read_value", e.read_value, d[32:1]);
      report("entry_count", 32'(e.entry_count), 32'(d[39:33]));
      report("is_empty", 32'(e.is_empty), 32'(d[40]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [6:0]  cfg_wr_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  list_scoreboard sb = new();
  int burst_left = 1;
  int hold_requests = 0;
  int hold_served;
  int hold_left;
  logic [9:0] rx_tick;
  int cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sequential_list_engine_unit #(.DEPTH(DEPTH)) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  // receiver: rotating stall pattern, plus long holds on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_tick <= '0;
      hold_served <= 0;
      hold_left <= 0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= LONG_HOLD;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 1'b1;
      case (rx_tick[9:8])
        2'd0: m_tready <= 1'b1;
        2'd1: m_tready <= 1'($urandom_range(0, 1));
        2'd2: m_tready <= (rx_tick[1:0] == 2'd0);
        default: m_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic send_item(sle_pkg::action_t act, logic signed [6:0] pos, logic [31:0] wval);
    s_tvalid <= 1'b1;
    s_tdata <= {7'b0, wval, pos, act};
    do @(posedge clk); while (!s_tready);
    sb.note_request(act, pos, wval);
    burst_left--;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
  endtask

  task automatic write_capacity(logic [6:0] value);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_data <= value;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_capacity(value);
  endtask

  task automatic send_random(int w_find, int w_ins, int w_del);
    int r;
    int p;
    int cnt;
    sle_pkg::action_t act;
    logic [31:0] wval;
    cnt = sb.count;
    r = $urandom_range(0, 99);
    if (r < w_find) act = sle_pkg::ACT_FIND;
    else if (r < w_find + w_ins) act = sle_pkg::ACT_INSERT;
    else if (r < w_find + w_ins + w_del) act = sle_pkg::ACT_DELETE;
    else act = sle_pkg::ACT_UPDATE;
    if ($urandom_range(0, 99) < 85) begin
      if (act == sle_pkg::ACT_INSERT) p = int'($urandom_range(0, cnt)) - 1;
      else if (cnt > 0) p = $urandom_range(0, cnt - 1);
      else p = 0;
    end else begin
      p = int'($urandom_range(0, 127)) - 64;
    end
    case ($urandom_range(0, 15))
      0: wval = 32'h8000_0000;
      1: wval = 32'h7fff_ffff;
      default: wval = $urandom;
    endcase
    send_item(act, p[6:0], wval);
  endtask

  task automatic run_phase(int n, int w_find, int w_ins, int w_del);
    repeat (n) send_random(w_find, w_ins, w_del);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    write_capacity(7'd64);

    // empty list
    send_item(sle_pkg::ACT_FIND, 0, 32'h0);
    send_item(sle_pkg::ACT_DELETE, 0, 32'h0);
    send_item(sle_pkg::ACT_UPDATE, 0, 32'h1);
    send_item(sle_pkg::ACT_INSERT, 0, 32'h2);
    // inserts at front, end and middle
    send_item(sle_pkg::ACT_INSERT, -1, 32'h8000_0000);
    send_item(sle_pkg::ACT_INSERT, -1, 32'h7fff_ffff);
    send_item(sle_pkg::ACT_INSERT, 1, 32'h0000_0000);
    send_item(sle_pkg::ACT_INSERT, 0, 32'hffff_ffff);
    send_item(sle_pkg::ACT_FIND, 0, 32'h0);
    send_item(sle_pkg::ACT_FIND, 1, 32'h0);
    send_item(sle_pkg::ACT_FIND, 2, 32'h0);
    send_item(sle_pkg::ACT_FIND, 3, 32'h0);
    // bad positions, then an in-range update, find and deletes
    send_item(sle_pkg::ACT_FIND, 4, 32'h0);
    send_item(sle_pkg::ACT_FIND, -1, 32'h0);
    send_item(sle_pkg::ACT_FIND, -64, 32'h0);
    send_item(sle_pkg::ACT_INSERT, -64, 32'h5);
    send_item(sle_pkg::ACT_INSERT, -2, 32'h6);
    send_item(sle_pkg::ACT_UPDATE, 63, 32'h7);
    send_item(sle_pkg::ACT_FIND, 63, 32'h0);
    send_item(sle_pkg::ACT_UPDATE, 3, 32'h1234_5678);
    send_item(sle_pkg::ACT_FIND, 3, 32'h0);
    send_item(sle_pkg::ACT_DELETE, 3, 32'h0);
    send_item(sle_pkg::ACT_DELETE, 0, 32'h0);
    send_item(sle_pkg::ACT_DELETE, 1, 32'h0);
    send_item(sle_pkg::ACT_FIND, 0, 32'h0);

    run_phase(150, 20, 40, 20);
    // push toward a full list
    run_phase(100, 15, 70, 5);
    // capacity below the current count
    write_capacity(7'd5);
    run_phase(80, 10, 30, 50);
    write_capacity(7'd0);
    run_phase(30, 25, 40, 10);
    write_capacity(7'd1);
    run_phase(40, 25, 40, 15);
    write_capacity(7'd63);
    run_phase(120, 15, 55, 10);
    write_capacity(7'd64);
    hold_requests++;
    run_phase(130, 25, 35, 20);

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DEPTH + 16) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sequential_list_engine_unit.f
rtl/sle_pkg.sv
rtl/sle_cell.sv
rtl/sle_ctrl.sv
rtl/sequential_list_engine_unit.sv
tb/sequential_list_engine_unit_tb.sv
